@@ design/rmbv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmbv_pkg
// Shared types and constants for the root manifest block validator.
// ----------------------------------------------------------------------------
package rmbv_pkg;

  // "TSFM" read as a little-endian word
  localparam logic [31:0] MagicLe = 32'h4D465354;
  // flag bit that marks a block's records as unnamed
  localparam int unsigned UnnamedBit = 28;
  // position of the flag bit inside the 64-bit block header store
  localparam int unsigned UnnamedHdrBit = 32 + UnnamedBit;
  // record sizes in bytes
  localparam int unsigned NamedRecord = 28;
  localparam int unsigned UnnamedRecord = 20;
  // header counts that announce the long header, and its length
  localparam logic [31:0] LongHeaderTotal = 32'd24;
  localparam logic [31:0] LongHeaderNamed = 32'd1;
  localparam logic [4:0] LongHeaderLen = 5'd24;
  // manifest header end position and block header length
  localparam logic [4:0] ShortHeaderLen = 5'd12;
  localparam logic [4:0] MagicLen = 5'd4;
  localparam logic [3:0] BlockHdrLen = 4'd12;
  localparam logic [3:0] BlockHdrKept = 4'd8;
  // width of the record byte countdown
  localparam int unsigned BodyWidth = 37;

  // result status codes
  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusShortHdr = 2'd1,
    StatusTrunc    = 2'd2,
    StatusMismatch = 2'd3
  } status_e;

  // one result of the validator
  typedef struct packed {
    status_e     status;
    logic        legacy_mode;
    logic [31:0] total_count;
    logic [31:0] named_count;
  } result_t;

endpackage
`default_nettype wire

@@ design/root_manifest_block_validator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// root_manifest_block_validator
// Checks a root manifest streamed one byte per request and reports its
// layout, file counts and status on the final byte.
// ----------------------------------------------------------------------------
// The block takes one manifest byte per clock cycle for as long as the result
// side keeps up. Each byte is held in an input register while the parser
// state is updated; when the byte marked last steps out of the input register,
// the result is written to the output register, so each result passes through
// both registers, and the following byte starts a new manifest with no gap.
// Input stalls only while a finished result is still held at the output and
// the next final byte is waiting behind it.
module root_manifest_block_validator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic             legacy_mode_o,
  output logic [31:0]      total_count_o,
  output logic [31:0]      named_count_o
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              in_last_q;
  logic              out_valid_q;
  rmbv_pkg::result_t result_q;
  rmbv_pkg::result_t parse_result;
  logic              out_free;
  logic              step;
  logic              in_accept;

  // handshake between the input register and the output register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && (!in_last_q || out_free);
  assign in_stall_o = in_valid_q && !step;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  rmbv_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .result_o    (parse_result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      result_q <= parse_result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = result_q.status;
  assign legacy_mode_o = result_q.legacy_mode;
  assign total_count_o = result_q.total_count;
  assign named_count_o = result_q.named_count;

endmodule
`default_nettype wire

@@ design/rmbv_parse.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rmbv_parse
// Byte-wise parser state: magic check, manifest headers, block headers and
// record skipping, with the result worked out on the final byte.
// ----------------------------------------------------------------------------
module rmbv_parse (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             last_byte_i,
  output rmbv_pkg::result_t     result_o
);

  typedef enum logic [4:0] {
    PhMagic    = 5'b00001,
    PhHead     = 5'b00010,
    PhLongHead = 5'b00100,
    PhBlkHdr   = 5'b01000,
    PhBody     = 5'b10000
  } phase_e;

  localparam int unsigned BW = rmbv_pkg::BodyWidth;

  phase_e        phase_q, phase_d;
  logic [4:0]    pos_q, pos_d;
  logic          legacy_q, legacy_d;
  logic [31:0]   exp_total_q, exp_total_d;
  logic [31:0]   exp_named_q, exp_named_d;
  logic [63:0]   hdr_q, hdr_d;
  logic [3:0]    hdr_idx_q, hdr_idx_d;
  logic [BW-1:0] body_q, body_d;
  logic [31:0]   sum_total_q, sum_total_d;
  logic [31:0]   sum_named_q, sum_named_d;

  logic [2:0]    k;
  logic [4:0]    kl;
  logic [31:0]   blk_count;
  logic          blk_unnamed;
  logic [BW-1:0] count_ext;
  logic [BW-1:0] blk_body;

  // record bytes of the current block, by constant shifts
  assign blk_count   = hdr_q[31:0];
  assign blk_unnamed = !legacy_q && hdr_q[rmbv_pkg::UnnamedHdrBit];
  assign count_ext   = {{(BW-32){1'b0}}, blk_count};
  assign blk_body    = blk_unnamed ? ((count_ext << 4) + (count_ext << 2))
                                   : ((count_ext << 5) - (count_ext << 2));

  // next state and result
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    legacy_d    = legacy_q;
    exp_total_d = exp_total_q;
    exp_named_d = exp_named_q;
    hdr_d       = hdr_q;
    hdr_idx_d   = hdr_idx_q;
    body_d      = body_q;
    sum_total_d = sum_total_q;
    sum_named_d = sum_named_q;
    k           = '0;
    kl          = '0;
    result_o    = '0;

    case (phase_q)
      PhMagic: begin
        k = {1'b0, pos_q[1:0]};
        hdr_d[{k, 3'b000} +: 8] = data_byte_i;
        pos_d = {3'b000, pos_q[1:0]} + 5'd1;
        if (pos_d == rmbv_pkg::MagicLen) begin
          if (hdr_d[31:0] == rmbv_pkg::MagicLe) begin
            phase_d = PhHead;
          end else begin
            legacy_d  = 1'b1;
            hdr_idx_d = 4'd4;
            phase_d   = PhBlkHdr;
          end
        end
      end
      PhHead: begin
        k = pos_q[2:0] - 3'd4;
        if (!k[2]) begin
          exp_total_d[{k[1:0], 3'b000} +: 8] = data_byte_i;
        end else begin
          exp_named_d[{k[1:0], 3'b000} +: 8] = data_byte_i;
        end
        pos_d = {2'b00, k} + 5'd5;
        if (pos_d == rmbv_pkg::ShortHeaderLen) begin
          if (exp_total_d == rmbv_pkg::LongHeaderTotal &&
              exp_named_d == rmbv_pkg::LongHeaderNamed) begin
            exp_total_d = '0;
            exp_named_d = '0;
            phase_d     = PhLongHead;
          end else begin
            hdr_d     = '0;
            hdr_idx_d = '0;
            phase_d   = PhBlkHdr;
          end
        end
      end
      PhLongHead: begin
        kl = pos_q - rmbv_pkg::ShortHeaderLen;
        if (kl > 5'd11) begin
          kl = 5'd11;
        end
        if (kl < 5'd4) begin
          exp_total_d[{kl[1:0], 3'b000} +: 8] = data_byte_i;
        end else if (kl < 5'd8) begin
          exp_named_d[{kl[1:0], 3'b000} +: 8] = data_byte_i;
        end
        pos_d = kl + 5'd13;
        if (pos_d == rmbv_pkg::LongHeaderLen) begin
          hdr_d     = '0;
          hdr_idx_d = '0;
          phase_d   = PhBlkHdr;
        end
      end
      PhBlkHdr: begin
        if (hdr_idx_q < rmbv_pkg::BlockHdrKept) begin
          hdr_d[{hdr_idx_q[2:0], 3'b000} +: 8] = data_byte_i;
        end
        hdr_idx_d = hdr_idx_q + 4'd1;
        // block header complete: add the counts, then skip its records
        if (hdr_idx_d >= rmbv_pkg::BlockHdrLen) begin
          sum_total_d = sum_total_q + blk_count;
          if (!blk_unnamed) begin
            sum_named_d = sum_named_q + blk_count;
          end
          hdr_d     = '0;
          hdr_idx_d = '0;
          phase_d   = PhBlkHdr;
          if (blk_body != '0) begin
            body_d  = blk_body;
            phase_d = PhBody;
          end
        end
      end
      PhBody: begin
        body_d = body_q - {{(BW-1){1'b0}}, 1'b1};
        if (body_d == '0) begin
          hdr_d     = '0;
          hdr_idx_d = '0;
          phase_d   = PhBlkHdr;
        end
      end
      default: begin
        phase_d = PhMagic;
      end
    endcase

    // result on the final byte
    if (phase_d == PhMagic || phase_d == PhHead || phase_d == PhLongHead) begin
      result_o.status = rmbv_pkg::StatusShortHdr;
    end else begin
      result_o.legacy_mode = legacy_d;
      if (phase_d == PhBody || hdr_idx_d != '0) begin
        result_o.status = rmbv_pkg::StatusTrunc;
      end else if (legacy_d) begin
        result_o.status      = rmbv_pkg::StatusOk;
        result_o.total_count = sum_total_d;
        result_o.named_count = sum_total_d;
      end else if (sum_total_d != exp_total_d || sum_named_d != exp_named_d) begin
        result_o.status      = rmbv_pkg::StatusMismatch;
        result_o.total_count = sum_total_d;
        result_o.named_count = sum_named_d;
      end else begin
        result_o.status      = rmbv_pkg::StatusOk;
        result_o.total_count = exp_total_d;
        result_o.named_count = exp_named_d;
      end
    end

    // a manifest ends on its final byte: start over
    if (last_byte_i) begin
      phase_d     = PhMagic;
      pos_d       = '0;
      legacy_d    = 1'b0;
      exp_total_d = '0;
      exp_named_d = '0;
      hdr_d       = '0;
      hdr_idx_d   = '0;
      body_d      = '0;
      sum_total_d = '0;
      sum_named_d = '0;
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhMagic;
      pos_q       <= '0;
      legacy_q    <= 1'b0;
      exp_total_q <= '0;
      exp_named_q <= '0;
      hdr_q       <= '0;
      hdr_idx_q   <= '0;
      body_q      <= '0;
      sum_total_q <= '0;
      sum_named_q <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      legacy_q    <= legacy_d;
      exp_total_q <= exp_total_d;
      exp_named_q <= exp_named_d;
      hdr_q       <= hdr_d;
      hdr_idx_q   <= hdr_idx_d;
      body_q      <= body_d;
      sum_total_q <= sum_total_d;
      sum_named_q <= sum_named_d;
    end
  end

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams root manifests, one byte per request, through the block validator.
// A parser model inside the bench predicts the report for each manifest.
// Every report is compared field by field with the oldest prediction.
// Covered: short and long headers, legacy layout, named and unnamed records,
// truncation, count mismatch, random noise and output backpressure.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DrainCycles = 8;
  localparam int LongHold = 80;

  // parser phases of the prediction model
  typedef enum logic [2:0] {
    PhMagic,
    PhHead,
    PhLongHead,
    PhBlockHdr,
    PhBody
  } parse_phase_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data = 8'h00;
  logic        in_last = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic        legacy_mode_o;
  logic [31:0] total_count_o;
  logic [31:0] named_count_o;

  // prediction state
  parse_phase_e parse_phase = PhMagic;
  int unsigned  hdr_pos = 0;
  logic         legacy_seen = 1'b0;
  logic [31:0]  hdr_total = '0;
  logic [31:0]  hdr_named = '0;
  logic [63:0]  blk_hdr = '0;
  int unsigned  blk_idx = 0;
  logic [36:0]  body_left = '0;
  logic [31:0]  sum_total = '0;
  logic [31:0]  sum_named = '0;

  rmbv_pkg::result_t expected_reports [$];
  logic [7:0]  manifest_bytes [$];
  int          fault_count = 0;
  int          sent_bytes = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  int          sink_hold_cycles = 0;

  root_manifest_block_validator u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (in_data),
    .last_byte_i   (in_last),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .status_o      (status_o),
    .legacy_mode_o (legacy_mode_o),
    .total_count_o (total_count_o),
    .named_count_o (named_count_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic void clear_parser();
    parse_phase = PhMagic;
    hdr_pos     = 0;
    legacy_seen = 1'b0;
    hdr_total   = '0;
    hdr_named   = '0;
    blk_hdr     = '0;
    blk_idx     = 0;
    body_left   = '0;
    sum_total   = '0;
    sum_named   = '0;
  endfunction

  function automatic void open_block();
    blk_hdr     = '0;
    blk_idx     = 0;
    parse_phase = PhBlockHdr;
  endfunction

  // add the block's counts and arm the record skip
  function automatic void close_block();
    logic [31:0] cnt;
    logic        unnamed;
    logic [36:0] span;
    cnt     = blk_hdr[31:0];
    unnamed = !legacy_seen && blk_hdr[rmbv_pkg::UnnamedHdrBit];
    span    = 37'(cnt) * (unnamed ? 37'(rmbv_pkg::UnnamedRecord)
                                  : 37'(rmbv_pkg::NamedRecord));
    sum_total += cnt;
    if (!unnamed) sum_named += cnt;
    open_block();
    if (span != 0) begin
      body_left   = span;
      parse_phase = PhBody;
    end
  endfunction

  function automatic void parse_manifest_byte(input logic [7:0] b, input logic is_last);
    int unsigned       k;
    rmbv_pkg::result_t rep;
    case (parse_phase)
      PhMagic: begin
        k = hdr_pos & 3;
        blk_hdr |= 64'(b) << (8 * k);
        hdr_pos = k + 1;
        if (hdr_pos == rmbv_pkg::MagicLen) begin
          if (blk_hdr[31:0] == rmbv_pkg::MagicLe) begin
            parse_phase = PhHead;
          end else begin
            // legacy: the magic bytes are already the first block's count
            legacy_seen = 1'b1;
            blk_idx     = 4;
            parse_phase = PhBlockHdr;
          end
        end
      end
      PhHead: begin
        k = (hdr_pos - 4) & 7;
        if (k < 4) hdr_total |= 32'(b) << (8 * k);
        else hdr_named |= 32'(b) << (8 * (k - 4));
        hdr_pos = k + 5;
        if (hdr_pos == rmbv_pkg::ShortHeaderLen) begin
          if (hdr_total == rmbv_pkg::LongHeaderTotal &&
              hdr_named == rmbv_pkg::LongHeaderNamed) begin
            hdr_total   = '0;
            hdr_named   = '0;
            parse_phase = PhLongHead;
          end else begin
            open_block();
          end
        end
      end
      PhLongHead: begin
        k = hdr_pos - 12;
        if (k > 11) k = 11;
        if (k < 4) hdr_total |= 32'(b) << (8 * k);
        else if (k < 8) hdr_named |= 32'(b) << (8 * (k - 4));
        hdr_pos = k + 13;
        if (hdr_pos == rmbv_pkg::LongHeaderLen) open_block();
      end
      PhBlockHdr: begin
        k = blk_idx;
        if (k < rmbv_pkg::BlockHdrKept) blk_hdr |= 64'(b) << (8 * k);
        blk_idx = k + 1;
        if (blk_idx >= rmbv_pkg::BlockHdrLen) close_block();
      end
      PhBody: begin
        if (body_left != 0) body_left--;
        if (body_left == 0) open_block();
      end
      default: ;
    endcase

    if (is_last) begin
      rep = '0;
      if (parse_phase == PhMagic || parse_phase == PhHead ||
          parse_phase == PhLongHead) begin
        rep.status = rmbv_pkg::StatusShortHdr;
      end else begin
        rep.legacy_mode = legacy_seen;
        if (parse_phase == PhBody || blk_idx != 0) begin
          rep.status = rmbv_pkg::StatusTrunc;
        end else if (legacy_seen) begin
          rep.status      = rmbv_pkg::StatusOk;
          rep.total_count = sum_total;
          rep.named_count = sum_total;
        end else if (sum_total != hdr_total || sum_named != hdr_named) begin
          rep.status      = rmbv_pkg::StatusMismatch;
          rep.total_count = sum_total;
          rep.named_count = sum_named;
        end else begin
          rep.status      = rmbv_pkg::StatusOk;
          rep.total_count = hdr_total;
          rep.named_count = hdr_named;
        end
      end
      expected_reports.push_back(rep);
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------- driving
  // one byte request, with an optional idle burst in front of it
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= value;
    in_last  <= is_last;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    sent_bytes++;
    parse_manifest_byte(value, is_last);
  endtask

  // send the built manifest, optionally cut after a given number of bytes
  task automatic send_manifest(input int cut);
    int n;
    n = manifest_bytes.size();
    if (cut > 0 && cut < n) n = cut;
    for (int i = 0; i < n; i++) send_byte(manifest_bytes[i], i == n - 1);
  endtask

  // hold off the sender until every report has come back
  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic void push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) manifest_bytes.push_back(w[8*i +: 8]);
  endfunction

  // build a manifest with small random record counts; header counts are corrupted unless exact is set
  task automatic compose_manifest(input bit legacy, input bit long_hdr, input int n_blocks,
                                  input int unnamed_pct, input bit exact);
    logic [31:0] blk_cnt [4];
    logic [31:0] blk_flags [4];
    logic [31:0] want_total;
    logic [31:0] want_named;
    bit          unnamed;
    want_total = '0;
    want_named = '0;
    manifest_bytes.delete();
    for (int i = 0; i < n_blocks; i++) begin
      blk_cnt[i]   = $urandom_range(0, 1);
      blk_flags[i] = $urandom;
      blk_flags[i][rmbv_pkg::UnnamedBit] = ($urandom_range(0, 99) < unnamed_pct);
      unnamed = !legacy && blk_flags[i][rmbv_pkg::UnnamedBit];
      want_total += blk_cnt[i];
      if (!unnamed) want_named += blk_cnt[i];
    end
    // corrupt the header counts for a mismatch
    if (!exact) begin
      case ($urandom_range(0, 2))
        0: want_total += 1;
        1: want_named += 32'($urandom_range(1, 3));
        default: begin
          want_total = $urandom;
          want_named = $urandom;
        end
      endcase
    end
    if (!legacy) begin
      push_word(rmbv_pkg::MagicLe);
      if (long_hdr) begin
        push_word(rmbv_pkg::LongHeaderTotal);
        push_word(rmbv_pkg::LongHeaderNamed);
      end
      push_word(want_total);
      push_word(want_named);
      if (long_hdr) push_word($urandom);
    end
    for (int i = 0; i < n_blocks; i++) begin
      push_word(blk_cnt[i]);
      push_word(blk_flags[i]);
      push_word($urandom);
      unnamed = !legacy && blk_flags[i][rmbv_pkg::UnnamedBit];
      repeat (blk_cnt[i] * (unnamed ? rmbv_pkg::UnnamedRecord : rmbv_pkg::NamedRecord))
        manifest_bytes.push_back(8'($urandom));
    end
  endtask

  // mostly well formed manifests, some noise, some cut short
  task automatic random_manifest();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      compose_manifest(1'b0, $urandom_range(0, 3) == 0, $urandom_range(0, 3), 50,
                       $urandom_range(0, 3) != 0);
    end else if (pick < 82) begin
      compose_manifest(1'b1, 1'b0, $urandom_range(1, 3), 50, 1'b1);
    end else begin
      manifest_bytes.delete();
      if ($urandom_range(0, 1)) push_word(rmbv_pkg::MagicLe);
      repeat ($urandom_range(1, 24)) manifest_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(0, 99) < 15) send_manifest($urandom_range(1, manifest_bytes.size()));
    else send_manifest(0);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_short_streams();
    manifest_bytes = '{8'h00};
    send_manifest(0);
    manifest_bytes = '{8'hFF, 8'hFF, 8'hFF};
    send_manifest(0);
    // magic alone, then magic with a header one byte short
    manifest_bytes.delete();
    push_word(rmbv_pkg::MagicLe);
    send_manifest(0);
    push_word($urandom);
    push_word($urandom);
    send_manifest(11);
    // four non-magic bytes open a legacy block that is never finished
    manifest_bytes = '{8'h01, 8'h00, 8'h00, 8'h00};
    send_manifest(0);
    wait_results();
  endtask

  task automatic test_manifest_layout();
    compose_manifest(1'b0, 1'b0, 0, 0, 1'b1);
    send_manifest(0);
    compose_manifest(1'b0, 1'b0, 1, 0, 1'b1);
    send_manifest(0);
    compose_manifest(1'b0, 1'b0, 1, 100, 1'b1);
    send_manifest(0);
    wait_results();
  endtask

  task automatic test_long_header();
    compose_manifest(1'b0, 1'b1, 1, 50, 1'b1);
    send_manifest(0);
    compose_manifest(1'b0, 1'b1, 1, 50, 1'b1);
    send_manifest(20);
    wait_results();
  endtask

  task automatic test_legacy_layout();
    // unnamed flag is ignored without the magic
    compose_manifest(1'b1, 1'b0, 2, 100, 1'b1);
    send_manifest(0);
    compose_manifest(1'b1, 1'b0, 1, 0, 1'b1);
    send_manifest(0);
    wait_results();
  endtask

  task automatic test_truncation();
    compose_manifest(1'b0, 1'b0, 1, 0, 1'b1);
    send_manifest(manifest_bytes.size() - 1);
    // all-ones block header cut one byte short
    manifest_bytes.delete();
    push_word(rmbv_pkg::MagicLe);
    push_word('1);
    push_word('0);
    push_word('1);
    push_word('1);
    repeat (3) manifest_bytes.push_back(8'hFF);
    send_manifest(0);
    wait_results();
  endtask

  task automatic test_count_mismatch();
    compose_manifest(1'b0, 1'b0, 1, 50, 1'b0);
    send_manifest(0);
    compose_manifest(1'b0, 1'b1, 1, 50, 1'b0);
    send_manifest(0);
    wait_results();
  endtask

  // receiver blocks for a long stretch while one-byte manifests pile up
  task automatic test_backpressure();
    src_idle_on      = 1'b0;
    sink_hold_cycles = LongHold;
    repeat (12) begin
      manifest_bytes = '{8'($urandom)};
      send_manifest(0);
    end
    src_idle_on = 1'b1;
    wait_results();
  endtask

  task automatic test_random_manifests();
    int start_bytes;
    int manifests;
    start_bytes = sent_bytes;
    manifests   = 0;
    while (sent_bytes - start_bytes < 40 || manifests < 2) begin
      random_manifest();
      manifests++;
    end
    wait_results();
  endtask

  task automatic test_steady_stream();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (2) random_manifest();
    wait_results();
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    clear_parser();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_streams();
    test_manifest_layout();
    test_long_header();
    test_legacy_layout();
    test_truncation();
    test_count_mismatch();
    test_backpressure();
    test_random_manifests();
    test_steady_stream();
    if (fault_count == 0 && expected_reports.size() == 0) begin
      $display("[root_manifest_block_validator] OK");
    end else begin
      $display("[root_manifest_block_validator] ERROR");
    end
    $finish;
  end

  // receiver side: random stall bursts and the requested long hold
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles != 0) begin
        out_stall <= 1'b1;
        n = sink_hold_cycles;
        sink_hold_cycles = 0;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // report check against the oldest prediction
  always @(posedge clk) begin
    rmbv_pkg::result_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (expected_reports.size() == 0) begin
        $error("report with nothing expected: status %0d", status_o);
        fault_count++;
      end else begin
        want = expected_reports.pop_front();
        if (status_o != want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fault_count++;
        end
        if (legacy_mode_o != want.legacy_mode) begin
          $error("legacy_mode: expected %0d, got %0d", want.legacy_mode, legacy_mode_o);
          fault_count++;
        end
        if (total_count_o != want.total_count) begin
          $error("total_count: expected %0h, got %0h", want.total_count, total_count_o);
          fault_count++;
        end
        if (named_count_o != want.named_count) begin
          $error("named_count: expected %0h, got %0h", want.named_count, named_count_o);
          fault_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[root_manifest_block_validator] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
design/rmbv_pkg.sv
design/rmbv_parse.sv
design/root_manifest_block_validator.sv
sim/testbench.sv
